[rtl/calc_pkg.sv]
// ----------------------------------------------------------------------------
// calc_pkg
// Types, codes and helpers shared by the two-operand decimal calculator.
// ----------------------------------------------------------------------------
package calc_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int OPERAND_BITS = 31;
  localparam int RESULT_BITS  = 32;
  localparam int DIV_STEPS    = OPERAND_BITS;
  localparam int CNT_BITS     = $clog2(DIV_STEPS);

  localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = '1;
  localparam logic [RESULT_BITS-1:0]  VALUE_MASK  =
    (VALUE_BITS >= RESULT_BITS) ? {RESULT_BITS{1'b1}}
                                : RESULT_BITS'((64'd1 << VALUE_BITS) - 64'd1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_DIV0   = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef enum logic [2:0] {
    S_FIRST,
    S_SECOND,
    S_IGNORE,
    S_EXEC,
    S_DIVIDE,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_data_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [31:0]      value;
    logic [OPERAND_BITS-1:0] left_operand;
    logic [OPERAND_BITS-1:0] right_operand;
    logic [1:0]              operation;
  } out_data_t;

  typedef struct packed {
    logic acc_first;
    logic acc_second;
    logic set_op;
    logic set_bad;
    logic exec;
    logic div_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic div_run;
  } sts_t;

  // acc * 10 + digit, held at the operand ceiling
  function automatic logic [OPERAND_BITS-1:0] acc_digit(
    input logic [OPERAND_BITS-1:0] acc,
    input logic [3:0]              digit
  );
    logic [OPERAND_BITS+3:0] nxt;
    nxt = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{OPERAND_BITS{1'b0}}, digit};
    if (nxt > {4'b0000, OPERAND_MAX}) begin
      return OPERAND_MAX;
    end
    return nxt[OPERAND_BITS-1:0];
  endfunction

endpackage

[rtl/calc_ctrl.sv]
// ----------------------------------------------------------------------------
// calc_ctrl
// Parse-phase and sequencing state machine, plus the output valid flag.
// ----------------------------------------------------------------------------
module calc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  calc_pkg::sts_t  sts,
  output calc_pkg::cmd_t  cmd
);

  calc_pkg::state_t               state_r, state_nxt;
  logic [calc_pkg::CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           in_fire;
  logic                           slot_free;

  assign in_ready  = (state_r == calc_pkg::S_FIRST) || (state_r == calc_pkg::S_SECOND) ||
                     (state_r == calc_pkg::S_IGNORE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      calc_pkg::S_FIRST: begin
        if (in_fire) begin
          if (in_last)           state_nxt = calc_pkg::S_EXEC;
          else if (sts.is_digit) state_nxt = calc_pkg::S_FIRST;
          else if (sts.is_op)    state_nxt = calc_pkg::S_SECOND;
          else                   state_nxt = calc_pkg::S_IGNORE;
        end
      end
      calc_pkg::S_SECOND: begin
        if (in_fire) begin
          if (in_last)            state_nxt = calc_pkg::S_EXEC;
          else if (!sts.is_digit) state_nxt = calc_pkg::S_IGNORE;
        end
      end
      calc_pkg::S_IGNORE: begin
        if (in_fire && in_last) state_nxt = calc_pkg::S_EXEC;
      end
      calc_pkg::S_EXEC: begin
        state_nxt = sts.div_run ? calc_pkg::S_DIVIDE : calc_pkg::S_LOAD;
      end
      calc_pkg::S_DIVIDE: begin
        if (cnt_r == '0) state_nxt = calc_pkg::S_LOAD;
      end
      calc_pkg::S_LOAD: begin
        if (slot_free) state_nxt = calc_pkg::S_FIRST;
      end
      default: state_nxt = calc_pkg::S_FIRST;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      calc_pkg::S_FIRST: begin
        cmd.acc_first = in_fire && sts.is_digit;
        cmd.set_op    = in_fire && sts.is_op;
        // a line that ends before any operator counts as a bad operator
        cmd.set_bad   = in_fire && !sts.is_op && (!sts.is_digit || in_last);
      end
      calc_pkg::S_SECOND: begin
        cmd.acc_second = in_fire && sts.is_digit;
      end
      calc_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_nxt  = calc_pkg::CNT_BITS'(calc_pkg::DIV_STEPS - 1);
      end
      calc_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
      end
      calc_pkg::S_LOAD: begin
        cmd.load = slot_free;
        if (slot_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= calc_pkg::S_FIRST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/calc_dp.sv]
// ----------------------------------------------------------------------------
// calc_dp
// Operand accumulators, multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
module calc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  calc_pkg::in_data_t  in_data,
  input  calc_pkg::cmd_t      cmd,
  output calc_pkg::sts_t      sts,
  output calc_pkg::out_data_t out_data
);

  localparam int OB = calc_pkg::OPERAND_BITS;
  localparam int RB = calc_pkg::RESULT_BITS;

  logic [OB-1:0] first_r;
  logic [OB-1:0] second_r;
  logic [1:0]    op_r;
  logic          bad_r;
  logic [RB-1:0] mul_r;
  logic [OB-1:0] rem_r;
  logic [OB-1:0] quo_r;
  calc_pkg::out_data_t out_r;

  logic [3:0]    digit;
  logic [1:0]    op_code;
  logic          op_hit;
  logic [OB:0]   shifted;
  logic          ge;
  logic [OB:0]   diff;
  logic [RB-1:0] left_x;
  logic [RB-1:0] right_x;
  logic [RB-1:0] raw;
  calc_pkg::out_data_t res;

  assign digit = 4'(in_data.character - calc_pkg::CH_ZERO);
  assign sts.is_digit = (in_data.character >= calc_pkg::CH_ZERO) &&
                        (in_data.character <= calc_pkg::CH_NINE);

  always_comb begin
    op_hit  = 1'b1;
    op_code = calc_pkg::OP_ADD;
    case (in_data.character)
      calc_pkg::CH_PLUS:  op_code = calc_pkg::OP_ADD;
      calc_pkg::CH_MINUS: op_code = calc_pkg::OP_SUB;
      calc_pkg::CH_STAR:  op_code = calc_pkg::OP_MUL;
      calc_pkg::CH_SLASH: op_code = calc_pkg::OP_DIV;
      default:            op_hit  = 1'b0;
    endcase
  end

  assign sts.is_op   = op_hit;
  assign sts.div_run = (op_r == calc_pkg::OP_DIV) && !bad_r && (second_r != '0);

  // one restoring division step per cycle, dividend bits enter MSB first
  assign shifted = {rem_r, quo_r[OB-1]};
  assign ge      = shifted >= {1'b0, second_r};
  assign diff    = shifted - {1'b0, second_r};

  assign left_x  = RB'(first_r);
  assign right_x = RB'(second_r);

  always_comb begin
    case (op_r)
      calc_pkg::OP_ADD: raw = left_x + right_x;
      calc_pkg::OP_SUB: raw = left_x - right_x;
      calc_pkg::OP_MUL: raw = mul_r;
      default:          raw = RB'(quo_r);
    endcase
    res.left_operand  = first_r;
    res.right_operand = second_r;
    res.operation     = op_r;
    res.status        = calc_pkg::ST_OK;
    res.value         = raw & calc_pkg::VALUE_MASK;
    if (bad_r) begin
      res.status        = calc_pkg::ST_BAD_OP;
      res.value         = '0;
      res.right_operand = '0;
      res.operation     = calc_pkg::OP_ADD;
    end else if ((op_r == calc_pkg::OP_DIV) && (second_r == '0)) begin
      res.status = calc_pkg::ST_DIV0;
      res.value  = '0;
    end
  end

  // parse state, cleared on reset and when the result is handed to the output register
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      first_r  <= '0;
      second_r <= '0;
      op_r     <= calc_pkg::OP_ADD;
      bad_r    <= 1'b0;
    end else begin
      if (cmd.acc_first)  first_r  <= calc_pkg::acc_digit(first_r, digit);
      if (cmd.acc_second) second_r <= calc_pkg::acc_digit(second_r, digit);
      if (cmd.set_op)     op_r     <= op_code;
      if (cmd.set_bad)    bad_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      // low word of the product is all the result keeps
      mul_r <= left_x * right_x;
      rem_r <= '0;
      quo_r <= first_r;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[OB-1:0] : shifted[OB-1:0];
      quo_r <= {quo_r[OB-2:0], ge};
    end
    if (cmd.load) out_r <= res;
  end

  assign out_data = out_r;

endmodule

[rtl/infix_two_operand_calculator_top.sv]
// Characters without last are taken back to back while parsing. On the last one, the
// FSM runs S_EXEC, S_DIVIDE when dividing by non-zero, then S_LOAD, which loads the result
// when the output is free. The 31-step restoring divider makes one quotient bit per cycle.
// No new character is taken from the last one until its result is in the output register.
// Reset (rst_n low, synchronous) clears the parse state, the operands and out_valid.
// ----------------------------------------------------------------------------
// infix_two_operand_calculator_top
// Two-operand decimal calculator fed one ASCII character per transfer.
// ----------------------------------------------------------------------------
module infix_two_operand_calculator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  calc_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output calc_pkg::out_data_t out_data
);

  calc_pkg::cmd_t cmd;
  calc_pkg::sts_t sts;

  calc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  calc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[rtl/calc_chk.sv]
// ----------------------------------------------------------------------------
// calc_chk
// Port-level checks on the calculator's result channel.
// ----------------------------------------------------------------------------
module calc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input calc_pkg::out_data_t out_data
);

  logic [31:0] sum_chk;
  assign sum_chk = 32'(out_data.left_operand) + 32'(out_data.right_operand);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("unused status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != calc_pkg::ST_OK |-> out_data.value == '0)
    else $error("non-zero value with error status");

  a_bad_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == calc_pkg::ST_BAD_OP |->
      out_data.right_operand == '0 && out_data.operation == calc_pkg::OP_ADD)
    else $error("bad-operator result shows operands");

  a_add_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == calc_pkg::ST_OK &&
      out_data.operation == calc_pkg::OP_ADD |->
      out_data.value == (sum_chk & calc_pkg::VALUE_MASK))
    else $error("sum mismatch");

endmodule

bind infix_two_operand_calculator_top calc_chk u_calc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[test/calc_line_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calc_line_checker
// Watches both channels of the calculator, parses every accepted character
// into its own copy of the line state and compares each result transfer,
// field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module calc_line_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  calc_pkg::in_data_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  calc_pkg::out_data_t out_data,
  output int unsigned         errors,
  output int unsigned         outstanding
);

  calc_pkg::state_t                  phase;
  logic [calc_pkg::OPERAND_BITS-1:0] first_num;
  logic [calc_pkg::OPERAND_BITS-1:0] second_num;
  logic [1:0]                        op_sel;
  logic                              bad_op;
  calc_pkg::out_data_t               expected_results[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic logic [calc_pkg::OPERAND_BITS-1:0] add_digit(
    input logic [calc_pkg::OPERAND_BITS-1:0] acc,
    input logic [7:0]                        ch
  );
    logic [63:0] nxt;
    nxt = 64'(acc) * 64'd10 + 64'(ch - calc_pkg::CH_ZERO);
    if (nxt > 64'(calc_pkg::OPERAND_MAX)) begin
      return calc_pkg::OPERAND_MAX;
    end
    return nxt[calc_pkg::OPERAND_BITS-1:0];
  endfunction

  task automatic clear_line();
    phase      = calc_pkg::S_FIRST;
    first_num  = '0;
    second_num = '0;
    op_sel     = calc_pkg::OP_ADD;
    bad_op     = 1'b0;
  endtask

  function automatic calc_pkg::out_data_t evaluate_line();
    calc_pkg::out_data_t r;
    logic [63:0]         wide;
    wide            = '0;
    r.status        = calc_pkg::ST_OK;
    r.value         = '0;
    r.left_operand  = first_num;
    r.right_operand = second_num;
    r.operation     = op_sel;
    // operator never seen, or not an operator: no arithmetic at all
    if (bad_op || phase == calc_pkg::S_FIRST) begin
      r.status        = calc_pkg::ST_BAD_OP;
      r.right_operand = '0;
      r.operation     = calc_pkg::OP_ADD;
    end else begin
      case (op_sel)
        calc_pkg::OP_ADD: wide = 64'(first_num) + 64'(second_num);
        calc_pkg::OP_SUB: wide = 64'(first_num) - 64'(second_num);
        calc_pkg::OP_MUL: wide = 64'(first_num) * 64'(second_num);
        default: begin
          if (second_num == '0) begin
            r.status = calc_pkg::ST_DIV0;
          end else begin
            wide = 64'(first_num / second_num);
          end
        end
      endcase
      r.value = wide[calc_pkg::RESULT_BITS-1:0] & calc_pkg::VALUE_MASK;
    end
    return r;
  endfunction

  task automatic take_character(input calc_pkg::in_data_t d);
    logic is_num;
    is_num = (d.character >= calc_pkg::CH_ZERO) && (d.character <= calc_pkg::CH_NINE);
    case (phase)
      calc_pkg::S_FIRST: begin
        if (is_num) begin
          first_num = add_digit(first_num, d.character);
        end else begin
          phase = calc_pkg::S_SECOND;
          case (d.character)
            calc_pkg::CH_PLUS:  op_sel = calc_pkg::OP_ADD;
            calc_pkg::CH_MINUS: op_sel = calc_pkg::OP_SUB;
            calc_pkg::CH_STAR:  op_sel = calc_pkg::OP_MUL;
            calc_pkg::CH_SLASH: op_sel = calc_pkg::OP_DIV;
            default: begin
              bad_op = 1'b1;
              phase  = calc_pkg::S_IGNORE;
            end
          endcase
        end
      end
      calc_pkg::S_SECOND: begin
        if (is_num) begin
          second_num = add_digit(second_num, d.character);
        end else begin
          phase = calc_pkg::S_IGNORE;
        end
      end
      default: ;
    endcase
    if (d.last) begin
      expected_results.push_back(evaluate_line());
      clear_line();
    end
  endtask

  task automatic check_result(input calc_pkg::out_data_t got);
    calc_pkg::out_data_t want;
    if (expected_results.size() == 0) begin
      $error("result transfer with nothing expected: value %0d", got.value);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
    if (got.value !== want.value) begin
      $error("value: expected %0d, got %0d", want.value, got.value);
      errors++;
    end
    if (got.left_operand !== want.left_operand) begin
      $error("left_operand: expected %0d, got %0d", want.left_operand, got.left_operand);
      errors++;
    end
    if (got.right_operand !== want.right_operand) begin
      $error("right_operand: expected %0d, got %0d", want.right_operand, got.right_operand);
      errors++;
    end
    if (got.operation !== want.operation) begin
      $error("operation: expected %0d, got %0d", want.operation, got.operation);
      errors++;
    end
  endtask

  // result side first: a result leaving now cannot belong to a line ending now
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
      end
      if (in_valid && in_ready) begin
        take_character(in_data);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the calculator directed and random expression lines, one character
// per transfer, with random idling on both sides; the checker does the rest.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned ITEM_TARGET = 1600;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  calc_pkg::in_data_t  in_data;
  logic                out_valid;
  logic                out_ready;
  calc_pkg::out_data_t out_data;
  int unsigned         errors;
  int unsigned         outstanding;

  logic [7:0]  line_buf[$];
  int unsigned chars_sent;
  bit          burst;

  infix_two_operand_calculator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  calc_line_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int unsigned digit_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 6);
    return $urandom_range(7, 11);
  endfunction

  function automatic logic [7:0] rand_digit();
    return calc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 3))
      0:       return calc_pkg::CH_PLUS;
      1:       return calc_pkg::CH_MINUS;
      2:       return calc_pkg::CH_STAR;
      default: return calc_pkg::CH_SLASH;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic is_last);
    int unsigned gap;
    @(negedge clk);
    gap = burst ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data.character <= ch;
    in_data.last      <= is_last;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) begin
      send_char(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic load_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) begin
      line_buf.push_back(s[i]);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic build_random_line();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    line_buf.delete();
    if (kind < 80) begin
      n = digit_count();
      repeat (n) line_buf.push_back(rand_digit());
      line_buf.push_back(rand_operator());
      n = digit_count();
      repeat (n) line_buf.push_back(rand_digit());
      n = $urandom_range(0, 2);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) begin
          line_buf.push_back(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 1) == 0) begin
          line_buf.push_back(rand_digit());
        end else begin
          line_buf.push_back(rand_operator());
        end
      end
    end else begin
      // cut short: the line ends inside the first number or on the operator
      n = $urandom_range(1, 5);
      repeat (n) line_buf.push_back(rand_digit());
      if ($urandom_range(0, 1) == 0) line_buf.push_back(rand_operator());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    int unsigned cyc;
    int unsigned stall_left;
    cyc        = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 1500) begin
        stall_left = 600;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    bit paused;
    chars_sent = 0;
    burst      = 1'b0;
    paused     = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    load_text("9/0");          send_line();
    load_text("5-9");          send_line();
    load_text("x");            send_line();
    load_text("7");            send_line();
    load_text("8*3q");         send_line();
    load_text("+");            send_line();
    load_text("99999999999/"); send_line();
    line_buf.delete();
    line_buf.push_back(8'hFF);
    send_line();
    drain();

    while (chars_sent < ITEM_TARGET) begin
      burst = ($urandom_range(0, 9) == 0);
      build_random_line();
      send_line();
      if (!paused && chars_sent >= ITEM_TARGET / 2) begin
        paused = 1'b1;
        drain();
      end
    end
    drain();
    repeat (40) @(negedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
